>>> rtl/wml_pkg.sv
// ----------------------------------------------------------------------------
// wml_pkg: shared definitions for the watermark flow controller
// Sizes, result and error codes, and the flag bundle from the arithmetic unit.
// ----------------------------------------------------------------------------
package wml_pkg;

	// wait list depth and stored handle width
	localparam int MAX_WAITERS = 32;
	localparam int HANDLE_BITS = 16;

	// derived widths
	localparam int IDX_W   = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
	localparam int CNT_W   = $clog2(MAX_WAITERS + 1);
	localparam int BYTES_W = 48;
	localparam int DELTA_W = 32;

	typedef logic [HANDLE_BITS-1:0] handle_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [BYTES_W-1:0]     bytes_t;
	typedef logic [DELTA_W-1:0]     delta_t;

	// input modes
	localparam logic MODE_ADD = 1'b0;
	localparam logic MODE_SUB = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_RESUME = 2'd1;
	localparam logic [1:0] KIND_SUB    = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_SAT   = 2'd1;
	localparam logic [1:0] ERR_UNDER = 2'd2;
	localparam logic [1:0] ERR_FULL  = 2'd3;

	// status from the arithmetic unit
	typedef struct packed {
		logic sat;    // add saturated the count
		logic under;  // sub clamped the count at zero
		logic hit;    // watermark test on the updated count
	} arith_flags_t;

endpackage

>>> rtl/wml_ram.sv
// ----------------------------------------------------------------------------
// wml_ram: wait list store
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module wml_ram (
	input  logic             clk,
	input  logic             we,
	input  wml_pkg::idx_t    waddr,
	input  wml_pkg::handle_t wdata,
	input  wml_pkg::idx_t    raddr,
	output wml_pkg::handle_t rdata
);

	wml_pkg::handle_t mem [wml_pkg::MAX_WAITERS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/wml_arith.sv
// ----------------------------------------------------------------------------
// wml_arith: byte count arithmetic
// Count update (saturating add, clamping sub) and the watermark tests.
// ----------------------------------------------------------------------------
module wml_arith (
	input  logic                  mode,
	input  wml_pkg::delta_t       delta,
	input  wml_pkg::bytes_t       count,
	input  wml_pkg::bytes_t       count_upd,
	input  wml_pkg::bytes_t       limit,
	output wml_pkg::bytes_t       next_count,
	output wml_pkg::arith_flags_t flags
);

	logic [wml_pkg::BYTES_W:0]   sum;
	logic                        under;
	logic [wml_pkg::BYTES_W:0]   reach;
	logic [wml_pkg::BYTES_W+1:0] lim3;

	// count update
	always_comb begin
		sum   = {1'b0, count} + (wml_pkg::BYTES_W + 1)'(delta);
		under = wml_pkg::BYTES_W'(delta) > count;
		if (mode == wml_pkg::MODE_ADD) begin
			next_count = sum[wml_pkg::BYTES_W] ? '1 : sum[wml_pkg::BYTES_W-1:0];
		end else begin
			next_count = under ? '0 : count - wml_pkg::BYTES_W'(delta);
		end
	end

	// watermark tests: high mark on add, three quarters on sub
	always_comb begin
		reach = {1'b0, count_upd} + (wml_pkg::BYTES_W + 1)'(delta >> 1);
		lim3  = {1'b0, limit, 1'b0} + {2'b00, limit};
		flags.sat   = sum[wml_pkg::BYTES_W];
		flags.under = under;
		if (mode == wml_pkg::MODE_ADD) begin
			flags.hit = reach >= {1'b0, limit};
		end else begin
			flags.hit = {count_upd, 2'b00} < lim3;
		end
	end

endmodule

>>> rtl/watermark_backpressure_waitlist.sv
// ----------------------------------------------------------------------------
// watermark_backpressure_waitlist: high/low watermark flow control
// Byte counter with a wait list of paused producers held in a synchronous RAM.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  command  | start, busy          | mode, byte_delta, producer_handle,
//           |                      | already_paused
//  result   | result_strobe        | kind, paused_now, resumed_handle,
//           |                      | last_of_run, waiting_count, error_code
//  config   | cfg_we               | cfg_wdata (byte limit)
//
//  An add or a sub without release keeps busy high through S_CALC and S_EVAL;
//  its result beat shows in the cycle after S_EVAL. A sub that releases n
//  producers then stays in S_DRAIN, one result beat per cycle, paced by the
//  wait list RAM read port. Reset clears the count, the list length and the
//  limit; the RAM needs no clearing. Results cannot be stalled.
// ----------------------------------------------------------------------------
module watermark_backpressure_waitlist (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [31:0] byte_delta,
	input  logic [15:0] producer_handle,
	input  logic        already_paused,
	input  logic        cfg_we,
	input  logic [47:0] cfg_wdata,
	output logic        result_strobe,
	output logic [1:0]  kind,
	output logic        paused_now,
	output logic [15:0] resumed_handle,
	output logic        last_of_run,
	output logic [5:0]  waiting_count,
	output logic [1:0]  error_code
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CALC  = 4'b0010,
		S_EVAL  = 4'b0100,
		S_DRAIN = 4'b1000
	} state_t;

	state_t                state_q;
	logic                  mode_q;
	wml_pkg::delta_t       delta_q;
	wml_pkg::handle_t      handle_q;
	logic                  paused_q;
	wml_pkg::bytes_t       count_q;
	wml_pkg::bytes_t       limit_q;
	wml_pkg::cnt_t         total_q;
	wml_pkg::cnt_t         k_q;
	logic [1:0]            err_q;

	wml_pkg::bytes_t       next_count;
	wml_pkg::arith_flags_t flags;

	logic                  ram_we;
	wml_pkg::idx_t         ram_raddr;
	wml_pkg::handle_t      ram_rdata;
	wml_pkg::cnt_t         k_next;
	logic                  k_last;

	assign busy   = (state_q != S_IDLE);
	assign k_next = k_q + wml_pkg::cnt_t'(1);
	assign k_last = (k_next == total_q);

	// push on an add that reaches the mark, from a producer not already paused, with room left
	assign ram_we = (state_q == S_EVAL) && (mode_q == wml_pkg::MODE_ADD) && flags.hit
	                && !paused_q && (total_q < wml_pkg::cnt_t'(wml_pkg::MAX_WAITERS));

	// read address runs one entry ahead of the drain index
	always_comb begin
		ram_raddr = '0;
		if (state_q == S_DRAIN) begin
			ram_raddr = k_next[wml_pkg::IDX_W-1:0];
		end
	end

	wml_arith u_arith (
		.mode       (mode_q),
		.delta      (delta_q),
		.count      (count_q),
		.count_upd  (count_q),
		.limit      (limit_q),
		.next_count (next_count),
		.flags      (flags)
	);

	wml_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (total_q[wml_pkg::IDX_W-1:0]),
		.wdata (handle_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// command capture
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_q   <= mode;
			delta_q  <= byte_delta;
			handle_q <= wml_pkg::handle_t'(producer_handle);
			paused_q <= already_paused;
		end
	end

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			total_q <= '0;
			k_q     <= '0;
			err_q   <= wml_pkg::ERR_NONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					count_q <= next_count;
					if (mode_q == wml_pkg::MODE_ADD) begin
						err_q <= flags.sat ? wml_pkg::ERR_SAT : wml_pkg::ERR_NONE;
					end else begin
						err_q <= flags.under ? wml_pkg::ERR_UNDER : wml_pkg::ERR_NONE;
					end
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					k_q <= '0;
					if (ram_we) begin
						total_q <= total_q + wml_pkg::cnt_t'(1);
					end
					if ((mode_q == wml_pkg::MODE_SUB) && flags.hit && (total_q != '0)) begin
						state_q <= S_DRAIN;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DRAIN: begin
					k_q <= k_next;
					if (k_last) begin
						total_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= ((state_q == S_EVAL) && !((mode_q == wml_pkg::MODE_SUB)
			                  && flags.hit && (total_q != '0))) || (state_q == S_DRAIN);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == S_DRAIN) begin
			kind           <= wml_pkg::KIND_RESUME;
			paused_now     <= 1'b0;
			resumed_handle <= 16'(ram_rdata);
			last_of_run    <= k_last;
			waiting_count  <= 6'(total_q - k_next);
			error_code     <= err_q;
		end else if (mode_q == wml_pkg::MODE_ADD) begin
			kind           <= wml_pkg::KIND_ADD;
			resumed_handle <= '0;
			last_of_run    <= 1'b1;
			if (flags.hit && !paused_q) begin
				if (ram_we) begin
					paused_now    <= 1'b1;
					waiting_count <= 6'(total_q + wml_pkg::cnt_t'(1));
					error_code    <= err_q;
				end else begin
					paused_now    <= 1'b0;
					waiting_count <= 6'(total_q);
					error_code    <= wml_pkg::ERR_FULL;
				end
			end else begin
				paused_now    <= paused_q;
				waiting_count <= 6'(total_q);
				error_code    <= err_q;
			end
		end else begin
			kind           <= wml_pkg::KIND_SUB;
			paused_now     <= 1'b0;
			resumed_handle <= '0;
			last_of_run    <= 1'b1;
			waiting_count  <= 6'(total_q);
			error_code     <= err_q;
		end
	end

endmodule

>>> tb/sv/wml_flow_checker.sv
// ----------------------------------------------------------------------------
// wml_flow_checker: scoreboard for the watermark flow controller
// Watches the command, config and result channels, keeps its own byte count
// and wait list, and compares each result beat with the oldest one predicted.
// ----------------------------------------------------------------------------
module wml_flow_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        mode,
	input  logic [31:0] byte_delta,
	input  logic [15:0] producer_handle,
	input  logic        already_paused,
	input  logic        cfg_we,
	input  logic [47:0] cfg_wdata,
	input  logic        result_strobe,
	input  logic [1:0]  kind,
	input  logic        paused_now,
	input  logic [15:0] resumed_handle,
	input  logic        last_of_run,
	input  logic [5:0]  waiting_count,
	input  logic [1:0]  error_code,
	output int          fail_count,
	output int          pending_count,
	output int          result_count,
	output int          resume_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// one result beat as it appears on the result ports
	typedef struct packed {
		logic [1:0]  kind;
		logic        paused;
		logic [15:0] handle;
		logic        last;
		logic [5:0]  waiting;
		logic [1:0]  err;
	} reply_t;

	reply_t  replies_due[$];
	reply_t  got;
	reply_t  want;

	// shadow of the block state
	wml_pkg::bytes_t  limit_bytes;
	wml_pkg::bytes_t  queued;
	wml_pkg::handle_t waitlist [wml_pkg::MAX_WAITERS];
	int               waiting;

	int fails = 0;
	int beats = 0;
	int resumes = 0;

	function automatic reply_t make_reply(input logic [1:0] k, input logic pz,
		input logic [15:0] h, input logic l, input int w, input logic [1:0] e);
		reply_t r;
		r.kind = k;
		r.paused = pz;
		r.handle = h;
		r.last = l;
		r.waiting = w[5:0];
		r.err = e;
		return r;
	endfunction

	// append one predicted beat at the tail of the queue
	task automatic queue_reply(input reply_t r);
		replies_due.insert(replies_due.size(), r);
	endtask

	// update the byte count and wait list for one command, queue its replies
	task automatic apply_command(input logic m, input logic [31:0] d,
		input logic [15:0] h, input logic p);
		logic [48:0] sum;
		logic [1:0]  err;
		logic        pz;
		err = wml_pkg::ERR_NONE;
		if (m == wml_pkg::MODE_ADD) begin
			sum = {1'b0, queued} + 49'(d);
			if (sum[48]) begin
				queued = '1;
				err = wml_pkg::ERR_SAT;
			end else begin
				queued = sum[47:0];
			end
			pz = p;
			// high watermark: count plus half the added amount
			if (64'(queued) + 64'(d >> 1) >= 64'(limit_bytes) && !p) begin
				if (waiting < wml_pkg::MAX_WAITERS) begin
					waitlist[waiting] = wml_pkg::handle_t'(h);
					waiting++;
					pz = 1'b1;
				end else begin
					err = wml_pkg::ERR_FULL;
					pz = 1'b0;
				end
			end
			queue_reply(make_reply(wml_pkg::KIND_ADD, pz, 16'd0, 1'b1, waiting, err));
		end else begin
			if (64'(d) > 64'(queued)) begin
				queued = '0;
				err = wml_pkg::ERR_UNDER;
			end else begin
				queued = queued - wml_pkg::bytes_t'(d);
			end
			// low watermark: below three quarters of the limit releases everyone
			if ((64'(queued) << 2) < 64'(limit_bytes) * 64'd3 && waiting > 0) begin
				for (int k = 0; k < waiting; k++)
					queue_reply(make_reply(wml_pkg::KIND_RESUME, 1'b0, 16'(waitlist[k]),
						k == waiting - 1, waiting - k - 1, err));
				waiting = 0;
			end else begin
				queue_reply(make_reply(wml_pkg::KIND_SUB, 1'b0, 16'd0, 1'b1, waiting, err));
			end
		end
	endtask

	task automatic compare_field(input string field, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			fails++;
			if (fails <= 40)
				$display("%0t: %s mismatch on result beat %0d: expected %0h, actual %0h",
					$time, field, beats, exp_v, act_v);
		end
	endtask

	// results are checked before a new command is taken in the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_bytes = '0;
			queued = '0;
			waiting = 0;
			replies_due.delete();
		end else begin
			if (cfg_we)
				limit_bytes = cfg_wdata;
			if (result_strobe) begin
				got = {kind, paused_now, resumed_handle, last_of_run, waiting_count, error_code};
				beats++;
				if (kind == wml_pkg::KIND_RESUME)
					resumes++;
				if (replies_due.size() == 0) begin
					fails++;
					if (fails <= 40)
						$display("%0t: unexpected result beat: expected none, actual %0h",
							$time, got);
				end else begin
					want = replies_due.pop_front();
					compare_field("kind", want.kind, got.kind);
					compare_field("paused_now", want.paused, got.paused);
					compare_field("resumed_handle", want.handle, got.handle);
					compare_field("last_of_run", want.last, got.last);
					compare_field("waiting_count", want.waiting, got.waiting);
					compare_field("error_code", want.err, got.err);
				end
			end
			if (start && !busy)
				apply_command(mode, byte_delta, producer_handle, already_paused);
		end
		fail_count <= fails;
		pending_count <= replies_due.size();
		result_count <= beats;
		resume_count <= resumes;
	end

endmodule

>>> tb/sv/watermark_backpressure_waitlist_tb.sv
// ----------------------------------------------------------------------------
// watermark_backpressure_waitlist_tb: top of the flow controller testbench
// Drives directed and random add/sub commands under several byte limits,
// fills the wait list past full, and reports the scoreboard verdict.
// ----------------------------------------------------------------------------
module watermark_backpressure_waitlist_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam wml_pkg::bytes_t FULL_SCALE = 48'hFFFF_FFFF_FFFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        mode = wml_pkg::MODE_ADD;
	logic [31:0] byte_delta = '0;
	logic [15:0] producer_handle = '0;
	logic        already_paused = 1'b0;
	logic        cfg_we = 1'b0;
	logic [47:0] cfg_wdata = '0;
	logic        busy;
	logic        result_strobe;
	logic [1:0]  kind;
	logic        paused_now;
	logic [15:0] resumed_handle;
	logic        last_of_run;
	logic [5:0]  waiting_count;
	logic [1:0]  error_code;

	int fail_count;
	int pending_count;
	int result_count;
	int resume_count;
	int commands = 0;
	int cycles = 0;

	watermark_backpressure_waitlist u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.byte_delta     (byte_delta),
		.producer_handle(producer_handle),
		.already_paused (already_paused),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.result_strobe  (result_strobe),
		.kind           (kind),
		.paused_now     (paused_now),
		.resumed_handle (resumed_handle),
		.last_of_run    (last_of_run),
		.waiting_count  (waiting_count),
		.error_code     (error_code)
	);

	wml_flow_checker u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.byte_delta     (byte_delta),
		.producer_handle(producer_handle),
		.already_paused (already_paused),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.result_strobe  (result_strobe),
		.kind           (kind),
		.paused_now     (paused_now),
		.resumed_handle (resumed_handle),
		.last_of_run    (last_of_run),
		.waiting_count  (waiting_count),
		.error_code     (error_code),
		.fail_count     (fail_count),
		.pending_count  (pending_count),
		.result_count   (result_count),
		.resume_count   (resume_count)
	);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d beats pending", cycles, pending_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// present one command and hold it until the block takes it;
	// start is left high so a following command can go back-to-back
	task automatic send(input logic m, input logic [31:0] d, input logic [15:0] h,
		input logic p);
		start <= 1'b1;
		mode <= m;
		byte_delta <= d;
		producer_handle <= h;
		already_paused <= p;
		do @(posedge clk); while (busy);
		commands++;
	endtask

	// stop sending until every predicted beat is back, then allow for latency
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limit(input wml_pkg::bytes_t lim);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly short gaps, now and then a long one
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// byte amounts scaled to the limit so the watermarks are actually crossed
	function automatic logic [31:0] pick_delta(input wml_pkg::bytes_t lim);
		wml_pkg::bytes_t scale;
		int unsigned     r;
		r = $urandom_range(0, 99);
		scale = lim / 3;
		if (scale > 48'hFFFF_FFFF)
			scale = 48'hFFFF_FFFF;
		if (scale == 0)
			scale = 1;
		if (r < 5)
			return 32'd0;
		if (r < 12)
			return 32'hFFFF_FFFF;
		if (r < 30)
			return $urandom();
		return $urandom_range(0, scale[31:0]);
	endfunction

	task automatic run_phase(input wml_pkg::bytes_t lim, input int n, input int add_pct);
		logic        m;
		int unsigned gap;
		set_limit(lim);
		for (int i = 0; i < n; i++) begin
			m = ($urandom_range(0, 99) < add_pct) ? wml_pkg::MODE_ADD : wml_pkg::MODE_SUB;
			send(m, pick_delta(lim), 16'($urandom()), $urandom_range(0, 99) < 15);
			gap = (i % 16 < 5) ? 0 : gap_len();
			if ($urandom_range(0, 99) < 3)
				settle();
			else if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero limit straight out of reset: every add pauses, no sub releases
		send(wml_pkg::MODE_ADD, 32'd0, 16'hFFFF, 1'b0);
		send(wml_pkg::MODE_ADD, 32'd0, 16'h1234, 1'b1);
		send(wml_pkg::MODE_SUB, 32'd0, 16'h0000, 1'b0);
		send(wml_pkg::MODE_SUB, 32'd5, 16'hFFFF, 1'b1);

		// small limit: pause, release in order, underflow
		set_limit(48'd100);
		send(wml_pkg::MODE_ADD, 32'hFFFF_FFFF, 16'h0000, 1'b0);
		send(wml_pkg::MODE_ADD, 32'd1, 16'hA5A5, 1'b0);
		send(wml_pkg::MODE_SUB, 32'hFFFF_FFFF, 16'h0000, 1'b0);
		send(wml_pkg::MODE_SUB, 32'hFFFF_FFFF, 16'h0000, 1'b0);
		send(wml_pkg::MODE_ADD, 32'd60, 16'h0001, 1'b0);
		send(wml_pkg::MODE_ADD, 32'd20, 16'h0002, 1'b0);
		send(wml_pkg::MODE_ADD, 32'd30, 16'h0003, 1'b0);
		send(wml_pkg::MODE_ADD, 32'd10, 16'h0004, 1'b1);
		send(wml_pkg::MODE_SUB, 32'd50, 16'h0000, 1'b0);
		send(wml_pkg::MODE_ADD, 32'd200, 16'h5A5A, 1'b0);
		send(wml_pkg::MODE_ADD, 32'd3, 16'h8001, 1'b0);
		// underflow error repeated on every resume beat
		send(wml_pkg::MODE_SUB, 32'hFFFF_FFFF, 16'h0000, 1'b0);
		settle();

		// random phases; the zero limit one fills the wait list past full
		run_phase(48'd0, 45, 95);
		run_phase(48'd5000, 30, 60);
		run_phase(wml_pkg::bytes_t'($urandom_range(1000, 131071)), 30, 60);
		run_phase((wml_pkg::bytes_t'($urandom_range(2, 7)) << 32)
			| wml_pkg::bytes_t'($urandom()), 30, 70);
		run_phase(48'd1, 20, 55);
		run_phase(FULL_SCALE, 15, 60);

		settle();
		repeat (10) @(posedge clk);
		$display("Run covered %0d commands under limits from zero to full scale", commands);
		$display("%0d result beats checked, %0d producer resumes, wait list driven past full",
			result_count, resume_count);
		if (fail_count == 0 && pending_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
